// ===== src/hav_pkg.sv =====
// Shared constants and the arctangent table for the great-circle distance pipeline.
package hav_pkg;

    localparam int CORDIC_STAGES_DEF = 32;

    // Widths: CORDIC datapath, angle differences, Q2.30 angles.
    localparam int CW    = 34;
    localparam int D_W   = 33;
    localparam int ANG_W = 31;

    localparam logic [31:0] PI_Q30       = 32'd3373259426;
    localparam logic [31:0] FULL_TURN    = 32'd3600000000;
    localparam logic [31:0] HALF_TURN    = 32'd1800000000;
    localparam logic [31:0] QUARTER_TURN = 32'd900000000;

    // Reciprocal of the full-turn conversion, floor(pi * 2^30 * 2^32 / 3.6e9).
    localparam logic [63:0] RECIP_WIDE = ({32'd0, PI_Q30} << 32) / {32'd0, FULL_TURN};
    localparam logic [31:0] RECIP      = RECIP_WIDE[31:0];

    localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;
    localparam logic [ANG_W-1:0] ONE_Q30      = 31'd1073741824;
    localparam logic [ANG_W-1:0] HALF_PI_Q30  = 31'd1686629713;
    localparam logic signed [63:0] ROUND_Q30  = 64'sd536870912;

    localparam logic [26:0] MM_SCALE = 27'd99546875;
    localparam int          MM_SHIFT = 23;

    localparam int          THR_W     = 20;
    localparam logic [19:0] THR_RESET = 20'd750;
    localparam int          DIST_W    = 35;

    // Square root: one result bit per stage.
    localparam int SQ_ITER = 31;
    localparam int SQ_W    = 62;

    // Register stages of the degree-to-radian conversion.
    localparam int Q30_LAT = 5;

    function automatic logic [31:0] atan_entry(input int unsigned i);
        logic [31:0] r;
        case (i)
            0: r = 32'h3243F6A8;
            1: r = 32'h1DAC6705;
            2: r = 32'h0FADBAFC;
            3: r = 32'h07F56EA6;
            4: r = 32'h03FEAB76;
            5: r = 32'h01FFD55B;
            6: r = 32'h00FFFAAA;
            7: r = 32'h007FFF55;
            8: r = 32'h003FFFEA;
            9: r = 32'h001FFFFD;
            default: begin
                if (i <= 30) r = (32'd1 << (30 - i)) - 32'd1;
                else         r = 32'd0;
            end
        endcase
        return r;
    endfunction

endpackage

// ===== src/hav_cordic.sv =====
// Pipelined CORDIC, one iteration per register stage, rotation or vectoring mode.
module hav_cordic #(
    parameter int STAGES = hav_pkg::CORDIC_STAGES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_vect,
    input  logic signed [hav_pkg::CW-1:0]  i_x,
    input  logic signed [hav_pkg::CW-1:0]  i_y,
    input  logic signed [hav_pkg::CW-1:0]  i_z,
    output logic signed [hav_pkg::CW-1:0]  o_x,
    output logic signed [hav_pkg::CW-1:0]  o_y,
    output logic signed [hav_pkg::CW-1:0]  o_z
);

    logic signed [hav_pkg::CW-1:0] r_x [STAGES];
    logic signed [hav_pkg::CW-1:0] r_y [STAGES];
    logic signed [hav_pkg::CW-1:0] r_z [STAGES];

    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        localparam logic signed [hav_pkg::CW-1:0] AT =
            $signed({2'b00, hav_pkg::atan_entry(i)});
        logic signed [hav_pkg::CW-1:0] x_in, y_in, z_in, dx, dy;
        logic dir;

        if (i == 0) begin : g_first
            assign x_in = i_x;
            assign y_in = i_y;
            assign z_in = i_z;
        end else begin : g_next
            assign x_in = r_x[i-1];
            assign y_in = r_y[i-1];
            assign z_in = r_z[i-1];
        end

        assign dx  = x_in >>> i;
        assign dy  = y_in >>> i;
        // Rotation drives z towards zero, vectoring drives y towards zero.
        assign dir = i_vect ? (y_in <= 0) : (z_in >= 0);

        always_ff @(posedge i_clk) begin
            r_x[i] <= dir ? x_in - dy : x_in + dy;
            r_y[i] <= dir ? y_in + dx : y_in - dx;
            r_z[i] <= dir ? z_in - AT : z_in + AT;
        end
    end

    assign o_x = r_x[STAGES-1];
    assign o_y = r_y[STAGES-1];
    assign o_z = r_z[STAGES-1];

endmodule

// ===== src/hav_isqrt.sv =====
// Pipelined integer square root, one result bit per register stage.
module hav_isqrt (
    input  logic                            i_clk,
    input  logic [hav_pkg::SQ_W-2:0]        i_v,
    output logic [hav_pkg::ANG_W-1:0]       o_r
);

    logic [hav_pkg::SQ_W-1:0] r_v [hav_pkg::SQ_ITER];
    logic [hav_pkg::SQ_W-1:0] r_r [hav_pkg::SQ_ITER];

    for (genvar k = 0; k < hav_pkg::SQ_ITER; k++) begin : g_bit
        localparam logic [hav_pkg::SQ_W-1:0] B =
            {{(hav_pkg::SQ_W-1){1'b0}}, 1'b1} << (2 * (hav_pkg::SQ_ITER - 1 - k));
        logic [hav_pkg::SQ_W-1:0] v_in, r_in, n_sum;
        logic n_ge;

        if (k == 0) begin : g_first
            assign v_in = {1'b0, i_v};
            assign r_in = '0;
        end else begin : g_next
            assign v_in = r_v[k-1];
            assign r_in = r_r[k-1];
        end

        assign n_sum = r_in + B;
        assign n_ge  = v_in >= n_sum;

        always_ff @(posedge i_clk) begin
            r_v[k] <= n_ge ? v_in - n_sum : v_in;
            r_r[k] <= n_ge ? (r_in >> 1) + B : r_in >> 1;
        end
    end

    assign o_r = r_r[hav_pkg::SQ_ITER-1][hav_pkg::ANG_W-1:0];

endmodule

// ===== src/haversine_distance_reach_check_unit.sv =====
// Top level of the great-circle distance and reach check pipeline.
//
//  Channel   Direction  Signals                                   Handshake
//  --------  ---------  ----------------------------------------  ------------------------
//  command   in         i_lat_a, i_lon_a, i_lat_b, i_lon_b        i_start while !o_busy
//  result    out        o_distance_mm, o_reached                  o_done, one cycle
//  config    in         i_cfg_wdata                               i_cfg_we
//
// A transaction is accepted on every cycle in which i_start is high; o_busy never rises,
// because every stage advances on every clock. Each result passes in order through the input
// stage, the degree-to-radian conversion, the rotation CORDIC pipelines of one iteration per
// stage, the haversine term, the 31-stage square root, the vectoring CORDIC and the output
// registers. Throughput is one transaction per cycle. The synchronous reset clears the valid
// line and loads the reach threshold with 750 mm; the datapath registers are not reset. The
// receiver cannot stall, so nothing is ever held back.
module haversine_distance_reach_check_unit #(
    parameter int CORDIC_STAGES = hav_pkg::CORDIC_STAGES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    output logic                             o_busy,
    input  logic signed [30:0]               i_lat_a,
    input  logic signed [31:0]               i_lon_a,
    input  logic signed [30:0]               i_lat_b,
    input  logic signed [31:0]               i_lon_b,
    input  logic                             i_cfg_we,
    input  logic [hav_pkg::THR_W-1:0]        i_cfg_wdata,
    output logic                             o_done,
    output logic [hav_pkg::DIST_W-1:0]       o_distance_mm,
    output logic                             o_reached
);

    // Stages the valid bit travels through before the output register.
    localparam int VLD_LEN = 1 + hav_pkg::Q30_LAT + CORDIC_STAGES + 3
                           + hav_pkg::SQ_ITER + CORDIC_STAGES + 1;
    localparam int NLANE = 4;

    logic [VLD_LEN-1:0]           r_vld;
    logic [hav_pkg::THR_W-1:0]    r_thr;

    assign o_busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_thr <= hav_pkg::THR_RESET;
        end else begin
            r_vld <= {r_vld[VLD_LEN-2:0], i_start};
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
        end
    end

    // Input stage. Lanes 0 and 1 hold the latitude and longitude differences, whose half
    // angles give the sine terms; lanes 2 and 3 hold the two latitudes for the cosines.
    logic signed [hav_pkg::D_W-1:0] r_d [NLANE];

    always_ff @(posedge i_clk) begin
        r_d[0] <= 33'(i_lat_b) - 33'(i_lat_a);
        r_d[1] <= 33'(i_lon_b) - 33'(i_lon_a);
        r_d[2] <= 33'(i_lat_a);
        r_d[3] <= 33'(i_lat_b);
    end

    // Conversion from 1e-7 degree units to Q2.30 radians over five stages. The divide by
    // the turn length is a reciprocal multiply whose estimate is at most one short, so a
    // single remainder compare finishes it. Difference lanes divide by a full turn (half
    // angle), latitude lanes by a half turn and fold past a quarter turn with a sign flag.
    logic [31:0]               r_u1  [NLANE];
    logic [hav_pkg::ANG_W-1:0] r_m   [NLANE];
    logic                      r_ng2 [NLANE];
    logic [62:0]               r_p1  [NLANE];
    logic [62:0]               r_p2  [NLANE];
    logic                      r_ng3 [NLANE];
    logic [62:0]               r_fd  [NLANE];
    logic [63:0]               r_n   [NLANE];
    logic [hav_pkg::ANG_W-1:0] r_f   [NLANE];
    logic                      r_ng4 [NLANE];
    logic [hav_pkg::ANG_W-1:0] r_q   [NLANE];
    logic                      r_qng [NLANE];

    for (genvar l = 0; l < NLANE; l++) begin : g_lane
        localparam bit          HALF = (l >= 2);
        localparam logic [31:0] DIV  = HALF ? hav_pkg::HALF_TURN : hav_pkg::FULL_TURN;
        localparam logic [31:0] THR  = HALF ? hav_pkg::QUARTER_TURN : hav_pkg::HALF_TURN;

        logic [hav_pkg::D_W-1:0]   n_abs, n_u1;
        logic [hav_pkg::ANG_W-1:0] n_f;
        logic [63:0]               n_rem;

        assign n_abs = r_d[l][hav_pkg::D_W-1] ? 33'(-r_d[l]) : 33'(r_d[l]);
        assign n_u1  = (n_abs >= {1'b0, hav_pkg::FULL_TURN})
                     ? n_abs - {1'b0, hav_pkg::FULL_TURN} : n_abs;
        assign n_f   = HALF ? r_p2[l][61:31] : r_p2[l][62:32];
        assign n_rem = r_n[l] - {1'b0, r_fd[l]};

        always_ff @(posedge i_clk) begin
            r_u1[l]  <= n_u1[31:0];

            if (r_u1[l] > THR) begin
                r_m[l]   <= 31'((HALF ? hav_pkg::HALF_TURN : hav_pkg::FULL_TURN) - r_u1[l]);
                r_ng2[l] <= HALF;
            end else begin
                r_m[l]   <= r_u1[l][hav_pkg::ANG_W-1:0];
                r_ng2[l] <= 1'b0;
            end

            r_p1[l]  <= r_m[l] * hav_pkg::PI_Q30;
            r_p2[l]  <= r_m[l] * hav_pkg::RECIP;
            r_ng3[l] <= r_ng2[l];

            r_fd[l]  <= n_f * DIV;
            r_n[l]   <= {1'b0, r_p1[l]} + {33'd0, DIV[31:1]};
            r_f[l]   <= n_f;
            r_ng4[l] <= r_ng3[l];

            r_q[l]   <= r_f[l] + 31'(n_rem >= {32'd0, DIV});
            r_qng[l] <= r_ng4[l];
        end
    end

    // Sine and cosine by rotation, one pipeline per lane.
    logic signed [hav_pkg::CW-1:0] w_cx [NLANE];
    logic signed [hav_pkg::CW-1:0] w_cy [NLANE];

    for (genvar l = 0; l < NLANE; l++) begin : g_rot
        hav_cordic #(.STAGES(CORDIC_STAGES)) u_rot (
            .i_clk  (i_clk),
            .i_vect (1'b0),
            .i_x    (hav_pkg::GAIN_Q30),
            .i_y    ('0),
            .i_z    ($signed({3'b000, r_q[l]})),
            .o_x    (w_cx[l]),
            .o_y    (w_cy[l]),
            .o_z    ()
        );
    end

    // The latitude fold flags ride alongside the rotation pipelines.
    logic [1:0] r_rneg [CORDIC_STAGES];

    always_ff @(posedge i_clk) begin
        r_rneg[0] <= {r_qng[2], r_qng[3]};
        for (int i = 1; i < CORDIC_STAGES; i++) begin
            r_rneg[i] <= r_rneg[i-1];
        end
    end

    // Haversine term: sine squares, cosine product times the longitude sine square, then the sum
    // clamped to the unit interval. Taking bits 63:30 of the rounded product is the floor shift.
    logic signed [31:0] n_s0, n_s1, n_ca, n_cb, n_cc32, n_sdn32;
    logic signed [63:0] n_sq0, n_sq1, n_pcc, n_pt;
    logic signed [34:0] n_a;
    logic signed [hav_pkg::CW-1:0] r_sdl, r_sdn, r_cc, r_sdl2, r_t;
    logic [hav_pkg::ANG_W-1:0] r_ay, r_ax, n_ac;

    assign n_s0    = w_cy[0][31:0];
    assign n_s1    = w_cy[1][31:0];
    assign n_ca    = r_rneg[CORDIC_STAGES-1][1] ? -w_cx[2][31:0] : w_cx[2][31:0];
    assign n_cb    = r_rneg[CORDIC_STAGES-1][0] ? -w_cx[3][31:0] : w_cx[3][31:0];
    assign n_sq0   = n_s0 * n_s0 + hav_pkg::ROUND_Q30;
    assign n_sq1   = n_s1 * n_s1 + hav_pkg::ROUND_Q30;
    assign n_pcc   = n_ca * n_cb + hav_pkg::ROUND_Q30;
    assign n_cc32  = r_cc[31:0];
    assign n_sdn32 = r_sdn[31:0];
    assign n_pt    = n_cc32 * n_sdn32 + hav_pkg::ROUND_Q30;
    assign n_a     = 35'(r_sdl2) + 35'(r_t);

    always_comb begin
        if (n_a < 0)                                    n_ac = '0;
        else if (n_a > $signed({4'd0, hav_pkg::ONE_Q30})) n_ac = hav_pkg::ONE_Q30;
        else                                            n_ac = n_a[hav_pkg::ANG_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        r_sdl  <= n_sq0[63:30];
        r_sdn  <= n_sq1[63:30];
        r_cc   <= n_pcc[63:30];
        r_sdl2 <= r_sdl;
        r_t    <= n_pt[63:30];
        r_ay   <= n_ac;
        r_ax   <= hav_pkg::ONE_Q30 - n_ac;
    end

    // sqrt(a) and sqrt(1 - a) in Q2.30.
    logic [hav_pkg::ANG_W-1:0] w_sqy, w_sqx;

    hav_isqrt u_sqrt_y (
        .i_clk (i_clk),
        .i_v   ({r_ay, 30'd0}),
        .o_r   (w_sqy)
    );

    hav_isqrt u_sqrt_x (
        .i_clk (i_clk),
        .i_v   ({r_ax, 30'd0}),
        .o_r   (w_sqx)
    );

    // Half the central angle as atan2(sqrt(a), sqrt(1 - a)) by vectoring.
    logic signed [hav_pkg::CW-1:0] w_vz;

    hav_cordic #(.STAGES(CORDIC_STAGES)) u_vec (
        .i_clk  (i_clk),
        .i_vect (1'b1),
        .i_x    ($signed({3'b000, w_sqx})),
        .i_y    ($signed({3'b000, w_sqy})),
        .i_z    ('0),
        .o_x    (),
        .o_y    (),
        .o_z    (w_vz)
    );

    // Clamp to a quarter turn and scale by twice the earth radius, rounding half up.
    logic [hav_pkg::ANG_W-1:0]  n_zc;
    logic [57:0]                n_prod;
    logic [hav_pkg::DIST_W-1:0] r_dist;
    logic [hav_pkg::DIST_W-1:0] r_out_dist;
    logic                       r_out_reached;
    logic                       r_done;

    always_comb begin
        if (w_vz < 0)                                           n_zc = '0;
        else if (w_vz > $signed({3'd0, hav_pkg::HALF_PI_Q30})) n_zc = hav_pkg::HALF_PI_Q30;
        else                                                    n_zc = w_vz[hav_pkg::ANG_W-1:0];
    end

    assign n_prod = n_zc * hav_pkg::MM_SCALE + (58'd1 << (hav_pkg::MM_SHIFT - 1));

    always_ff @(posedge i_clk) begin
        r_dist        <= n_prod[hav_pkg::MM_SHIFT +: hav_pkg::DIST_W];
        r_out_dist    <= r_dist;
        r_out_reached <= r_dist < {15'd0, r_thr};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_vld[VLD_LEN-1];
        end
    end

    assign o_done        = r_done;
    assign o_distance_mm = r_out_dist;
    assign o_reached     = r_out_reached;

    // A result strobe always belongs to a command the fixed latency earlier.
    a_done_has_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start, VLD_LEN + 1))
        else $error("result strobe without a matching command");

    // A reached flag can only go with a distance below the largest threshold.
    a_reached_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_reached) |-> (o_distance_mm < 35'd1048575))
        else $error("reached flag with a distance beyond any threshold");

endmodule
